@@ sv/bmmd_pkg.sv @@
package bmmd_pkg;

    // Field widths fixed by the access and result formats.
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned OFFSET_W = 21;

    // Access kinds carried in the func field.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Cartridge kinds held in the configuration register.
    localparam logic CART_NONE = 1'b0;
    localparam logic CART_MBC1 = 1'b1;

    // Target memory codes reported in the region field.
    typedef enum logic [2:0] {
        REGION_NONE = 3'd0,
        REGION_BOOT = 3'd1,
        REGION_ROM  = 3'd2,
        REGION_VRAM = 3'd3,
        REGION_ERAM = 3'd4,
        REGION_WRAM = 3'd5,
        REGION_ZERO = 3'd6,
        REGION_OAM  = 3'd7
    } t_region;

    // Bank controller register select, taken from address bits 14..13.
    typedef enum logic [1:0] {
        BANK_SEL_RAM_ENABLE = 2'd0,
        BANK_SEL_ROM_LOW    = 2'd1,
        BANK_SEL_UPPER      = 2'd2,
        BANK_SEL_MODE       = 2'd3
    } t_bank_sel;

    // Memory map boundaries.
    localparam logic [ADDR_W-1:0] ADDR_BOOT_END  = 16'h0100;
    localparam logic [ADDR_W-1:0] ADDR_BOOT_EXIT = 16'h1000;
    localparam logic [ADDR_W-1:0] ADDR_BANKED    = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM      = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_ERAM      = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WRAM      = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_OAM       = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_ZERO      = 16'hFF80;
    localparam logic [ADDR_W-1:0] ADDR_LAST      = 16'hFFFF;
    localparam logic [ADDR_W-1:0] PC_BOOT_EXIT   = 16'h0100;

    // Value written to the enable register that turns external RAM on.
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // Bank controller state visible to the decoder.
    typedef struct packed {
        logic       boot_rom_active;
        logic [6:0] rom_bank;
        logic [1:0] ram_bank;
        logic       banking_mode;
        logic       ram_enable;
    } t_bank_state;

    // State change requested by one decoded access.
    typedef struct packed {
        logic              ctrl_write;
        logic              boot_exit;
        t_bank_sel         sel;
        logic [DATA_W-1:0] value;
    } t_bank_cmd;

    // Decoded result of one access, without the RAM enable flag.
    typedef struct packed {
        t_region             region;
        logic [OFFSET_W-1:0] mem_offset;
        logic                write_enable;
        logic [DATA_W-1:0]   write_data;
    } t_decode;

endpackage

@@ sv/bmmd_if.sv @@
// Access request channel.
interface bmmd_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bmmd_pkg::ADDR_W-1:0]   address;
    logic [bmmd_pkg::DATA_W-1:0]   write_value;
    logic [bmmd_pkg::ADDR_W-1:0]   program_counter;

    modport source (output valid, func, address, write_value, program_counter,
                    input ready);
    modport sink   (input valid, func, address, write_value, program_counter,
                    output ready);
    modport mon    (input valid, ready, func, address, write_value, program_counter);
endinterface

// Decoded result channel.
interface bmmd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    region;
    logic [bmmd_pkg::OFFSET_W-1:0] mem_offset;
    logic                          write_enable;
    logic [bmmd_pkg::DATA_W-1:0]   write_data;
    logic                          ram_enabled;

    modport source (output valid, region, mem_offset, write_enable, write_data,
                    ram_enabled, input ready);
    modport sink   (input valid, region, mem_offset, write_enable, write_data,
                    ram_enabled, output ready);
    modport mon    (input valid, ready, region, mem_offset, write_enable, write_data,
                    ram_enabled);
endinterface

// Configuration write channel for the cartridge kind register.
interface bmmd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
    modport mon    (input valid, ready, data);
endinterface

@@ sv/bmmd_decode.sv @@
module bmmd_decode (
    input  logic                          i_func,
    input  logic [bmmd_pkg::ADDR_W-1:0]   i_address,
    input  logic [bmmd_pkg::DATA_W-1:0]   i_write_value,
    input  logic [bmmd_pkg::ADDR_W-1:0]   i_program_counter,
    input  bmmd_pkg::t_bank_state         i_state,
    output bmmd_pkg::t_decode             o_decode,
    output bmmd_pkg::t_bank_cmd           o_cmd
);

    logic wr;

    assign wr = (i_func == bmmd_pkg::FUNC_WRITE);

    // Address map decode against the current bank state.
    always_comb begin
        o_decode.region       = bmmd_pkg::REGION_NONE;
        o_decode.mem_offset   = '0;
        o_decode.write_enable = 1'b0;
        o_cmd.ctrl_write      = 1'b0;
        o_cmd.boot_exit       = 1'b0;
        o_cmd.sel             = bmmd_pkg::t_bank_sel'(i_address[14:13]);
        o_cmd.value           = i_write_value;

        if (i_address < bmmd_pkg::ADDR_VRAM) begin
            if (wr) begin
                // Writes to the ROM area program the bank controller.
                o_cmd.ctrl_write = 1'b1;
            end else if (i_address < bmmd_pkg::ADDR_BANKED) begin
                o_decode.region     = bmmd_pkg::REGION_ROM;
                o_decode.mem_offset = bmmd_pkg::OFFSET_W'(i_address);
                if (i_address < bmmd_pkg::ADDR_BOOT_EXIT && i_state.boot_rom_active) begin
                    if (i_address < bmmd_pkg::ADDR_BOOT_END) begin
                        o_decode.region = bmmd_pkg::REGION_BOOT;
                    end else if (i_program_counter == bmmd_pkg::PC_BOOT_EXIT) begin
                        o_cmd.boot_exit = 1'b1;
                    end
                end
            end else begin
                // Switchable bank: 16 KiB pages selected by the ROM bank.
                o_decode.region     = bmmd_pkg::REGION_ROM;
                o_decode.mem_offset = {i_state.rom_bank, i_address[13:0]};
            end
        end else if (i_address < bmmd_pkg::ADDR_ERAM) begin
            o_decode.region       = bmmd_pkg::REGION_VRAM;
            o_decode.mem_offset   = bmmd_pkg::OFFSET_W'(i_address[12:0]);
            o_decode.write_enable = wr;
        end else if (i_address < bmmd_pkg::ADDR_WRAM) begin
            // External RAM: 8 KiB pages selected by the RAM bank.
            o_decode.region       = bmmd_pkg::REGION_ERAM;
            o_decode.mem_offset   = bmmd_pkg::OFFSET_W'({i_state.ram_bank, i_address[12:0]});
            o_decode.write_enable = wr;
        end else if (i_address < bmmd_pkg::ADDR_OAM) begin
            // Work RAM and its echo share the same 8 KiB.
            o_decode.region       = bmmd_pkg::REGION_WRAM;
            o_decode.mem_offset   = bmmd_pkg::OFFSET_W'(i_address[12:0]);
            o_decode.write_enable = wr;
        end else if (i_address < bmmd_pkg::ADDR_UNMAPPED) begin
            o_decode.region = bmmd_pkg::REGION_OAM;
        end else if (i_address >= bmmd_pkg::ADDR_ZERO) begin
            // The last byte is only readable here; a write there goes nowhere.
            if (!wr || i_address != bmmd_pkg::ADDR_LAST) begin
                o_decode.region       = bmmd_pkg::REGION_ZERO;
                o_decode.mem_offset   = bmmd_pkg::OFFSET_W'(i_address[6:0]);
                o_decode.write_enable = wr;
            end
        end

        o_decode.write_data = o_decode.write_enable ? i_write_value : '0;
    end

endmodule

@@ sv/bmmd_bank_regs.sv @@
module bmmd_bank_regs (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_update,
    input  logic                    i_cartridge_kind,
    input  bmmd_pkg::t_bank_cmd     i_cmd,
    output bmmd_pkg::t_bank_state   o_state,
    output logic                    o_next_ram_enable
);

    logic       r_boot_rom_active;
    logic [6:0] r_rom_bank;
    logic [1:0] r_ram_bank;
    logic       r_banking_mode;
    logic       r_ram_enable;

    logic       n_boot_rom_active;
    logic [6:0] n_rom_bank;
    logic [1:0] n_ram_bank;
    logic       n_banking_mode;
    logic       n_ram_enable;
    logic [4:0] rom_low;
    logic       ctrl_en;

    assign ctrl_en = i_update && i_cmd.ctrl_write
                     && (i_cartridge_kind == bmmd_pkg::CART_MBC1);

    // A low bank field of zero selects bank one.
    assign rom_low = (i_cmd.value[4:0] == 5'd0) ? 5'd1 : i_cmd.value[4:0];

    // Next bank controller state for the accepted access.
    always_comb begin
        n_boot_rom_active = r_boot_rom_active;
        n_rom_bank        = r_rom_bank;
        n_ram_bank        = r_ram_bank;
        n_banking_mode    = r_banking_mode;
        n_ram_enable      = r_ram_enable;

        if (i_update && i_cmd.boot_exit) begin
            n_boot_rom_active = 1'b0;
        end

        if (ctrl_en) begin
            unique case (i_cmd.sel)
                bmmd_pkg::BANK_SEL_RAM_ENABLE: begin
                    n_ram_enable = (i_cmd.value[3:0] == bmmd_pkg::RAM_ENABLE_KEY);
                end
                bmmd_pkg::BANK_SEL_ROM_LOW: begin
                    n_rom_bank = {r_rom_bank[6:5], rom_low};
                end
                bmmd_pkg::BANK_SEL_UPPER: begin
                    if (r_banking_mode) begin
                        n_ram_bank = i_cmd.value[1:0];
                    end else begin
                        n_rom_bank = {i_cmd.value[1:0], r_rom_bank[4:0]};
                    end
                end
                bmmd_pkg::BANK_SEL_MODE: begin
                    n_banking_mode = i_cmd.value[0];
                end
                default: begin
                    n_banking_mode = r_banking_mode;
                end
            endcase
        end
    end

    // Bank controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_rom_active <= 1'b1;
            r_rom_bank        <= 7'd1;
            r_ram_bank        <= 2'd0;
            r_banking_mode    <= 1'b0;
            r_ram_enable      <= 1'b0;
        end else begin
            r_boot_rom_active <= n_boot_rom_active;
            r_rom_bank        <= n_rom_bank;
            r_ram_bank        <= n_ram_bank;
            r_banking_mode    <= n_banking_mode;
            r_ram_enable      <= n_ram_enable;
        end
    end

    assign o_state.boot_rom_active = r_boot_rom_active;
    assign o_state.rom_bank        = r_rom_bank;
    assign o_state.ram_bank        = r_ram_bank;
    assign o_state.banking_mode    = r_banking_mode;
    assign o_state.ram_enable      = r_ram_enable;
    assign o_next_ram_enable       = n_ram_enable;

endmodule

@@ sv/banked_memory_map_decoder.sv @@
// Memory map decoder with an MBC1-style bank controller.
// i_req carries one byte access per transfer: func, address, write_value and
// program_counter. o_rsp returns one result per access: target region, byte
// offset in that memory, write enable and data, and the RAM enable flag as it
// stands after the access. i_cfg writes the one-bit cartridge kind; it is
// always ready and should only be written while no access is in flight.
// The result is registered: an access accepted at a clock edge has its result
// on o_rsp after that edge. Throughput is one access per cycle while o_rsp is
// not stalled, set by the single result register; the decode and bank update
// sit between the request port and that register.
// When o_rsp is stalled the result register holds and i_req.ready drops, so
// nothing is lost; i_req.ready is high whenever the result register is empty
// or is being emptied in the same cycle.
// Reset clears the result register and puts the bank controller in its
// power-up state: boot ROM mapped, ROM bank one, RAM bank zero, ROM banking
// mode, RAM disabled, and no bank controller selected.
module banked_memory_map_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmmd_cfg_if.sink    i_cfg,
    bmmd_req_if.sink    i_req,
    bmmd_rsp_if.source  o_rsp
);

    logic                  r_cartridge_kind;
    logic                  r_rsp_valid;
    bmmd_pkg::t_decode     r_rsp;
    logic                  r_rsp_ram_enabled;

    logic                  req_fire;
    bmmd_pkg::t_bank_state bank_state;
    bmmd_pkg::t_bank_cmd   bank_cmd;
    bmmd_pkg::t_decode     decode;
    logic                  next_ram_enable;

    // Configuration register.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cartridge_kind <= bmmd_pkg::CART_NONE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cartridge_kind <= i_cfg.data;
        end
    end

    // Accept while the result register is free or draining.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;

    bmmd_decode u_decode (
        .i_func            (i_req.func),
        .i_address         (i_req.address),
        .i_write_value     (i_req.write_value),
        .i_program_counter (i_req.program_counter),
        .i_state           (bank_state),
        .o_decode          (decode),
        .o_cmd             (bank_cmd)
    );

    bmmd_bank_regs u_bank_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_update          (req_fire),
        .i_cartridge_kind  (r_cartridge_kind),
        .i_cmd             (bank_cmd),
        .o_state           (bank_state),
        .o_next_ram_enable (next_ram_enable)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (req_fire) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rsp             <= decode;
            r_rsp_ram_enabled <= next_ram_enable;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.region       = r_rsp.region;
    assign o_rsp.mem_offset   = r_rsp.mem_offset;
    assign o_rsp.write_enable = r_rsp.write_enable;
    assign o_rsp.write_data   = r_rsp.write_data;
    assign o_rsp.ram_enabled  = r_rsp_ram_enabled;

endmodule

@@ sv/bmmd_checker.sv @@
module bmmd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmmd_req_if.sink   i_req,
    bmmd_rsp_if.source o_rsp
);

    // An accepted access always leaves a result behind it.
    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> o_rsp.valid
    ) else $error("accepted access produced no result");

    // A stalled result blocks new accesses.
    a_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready
    ) else $error("access accepted while result is stalled");

    // Only writable memories are ever written.
    a_write_region: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.write_enable) |->
            (o_rsp.region == bmmd_pkg::REGION_VRAM || o_rsp.region == bmmd_pkg::REGION_ERAM
             || o_rsp.region == bmmd_pkg::REGION_WRAM
             || o_rsp.region == bmmd_pkg::REGION_ZERO)
    ) else $error("write enable on a read-only region");

    // A stalled result holds its payload.
    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
            (o_rsp.valid && $stable(o_rsp.region) && $stable(o_rsp.mem_offset)
             && $stable(o_rsp.write_data) && $stable(o_rsp.ram_enabled))
    ) else $error("stalled result changed");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
